>>> sv/frt_pkg.sv
// ----------------------------------------------------------------------------
// Fragment reassembly tracker package
// Shared constants, types and status codes.
// ----------------------------------------------------------------------------
package frt_pkg;

	localparam int TABLE_ENTRIES   = 16;
	localparam int MAX_FRAGMENTS   = 64;
	localparam int MIN_FRAME_BYTES = 38;
	localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int FNUM_W = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
	localparam int QDEPTH = 2;

	localparam logic CFG_ETHERTYPE = 1'b0;
	localparam logic CFG_BUF_LIMIT = 1'b1;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_RUNT      = 3'd1,
		ST_ETHERTYPE = 3'd2,
		ST_DUPLICATE = 3'd3,
		ST_OVERRUN   = 3'd4,
		ST_FULL      = 3'd5
	} status_t;

	typedef struct packed {
		logic [15:0] frame_length;
		logic [15:0] frame_ethertype;
		logic [63:0] tensor_tag;
		logic [31:0] total_bytes;
		logic [15:0] fragment_total;
		logic [15:0] fragment_number;
		logic [31:0] byte_offset;
		logic [15:0] payload_bytes;
	} frag_in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] write_offset;
		logic [15:0] write_length;
		logic        complete;
		logic [63:0] done_tensor_tag;
		logic [31:0] copy_length;
	} frag_out_t;

	// Item handed from the classifier to the table engine.
	typedef struct packed {
		logic        drop;
		status_t     drop_status;
		logic [63:0] tensor_tag;
		logic [31:0] total_bytes;
		logic [15:0] fragment_total;
		logic [15:0] fragment_number;
		logic [31:0] byte_offset;
		logic [15:0] payload_bytes;
	} work_t;

endpackage

>>> sv/frt_if.sv
// ----------------------------------------------------------------------------
// Fragment reassembly tracker channels
// Valid/ready request channels for fragment headers and results.
// ----------------------------------------------------------------------------
interface frt_in_if import frt_pkg::*; ();
	logic     valid;
	logic     ready;
	frag_in_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface frt_out_if import frt_pkg::*; ();
	logic      valid;
	logic      ready;
	frag_out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> sv/frt_front.sv
// ----------------------------------------------------------------------------
// Fragment reassembly tracker front end
// Accepts headers, screens runts and foreign ethertypes, and queues work.
// ----------------------------------------------------------------------------
module frt_front import frt_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	frt_in_if.sink       in_ch,
	input  logic [15:0]  ethertype,
	output logic         wq_valid,
	input  logic         wq_ready,
	output work_t        wq_data
);

	work_t                  mem_q [QDEPTH];
	logic [$clog2(QDEPTH):0] cnt_q;
	logic [$clog2(QDEPTH)-1:0] wp_q, rp_q;
	work_t                  w;
	logic                   push, pop;

	always_comb begin
		w.tensor_tag      = in_ch.data.tensor_tag;
		w.total_bytes     = in_ch.data.total_bytes;
		w.fragment_total  = in_ch.data.fragment_total;
		w.fragment_number = in_ch.data.fragment_number;
		w.byte_offset     = in_ch.data.byte_offset;
		w.payload_bytes   = in_ch.data.payload_bytes;
		w.drop            = 1'b1;
		w.drop_status     = ST_RUNT;
		if (in_ch.data.frame_length < 16'(MIN_FRAME_BYTES)) begin
			w.drop_status = ST_RUNT;
		end else if (in_ch.data.frame_ethertype != ethertype) begin
			w.drop_status = ST_ETHERTYPE;
		end else begin
			w.drop = 1'b0;
			w.drop_status = ST_OK;
		end
	end

	assign in_ch.ready = (cnt_q != ($clog2(QDEPTH)+1)'(QDEPTH));
	assign push = in_ch.valid && in_ch.ready;
	assign wq_valid = (cnt_q != '0);
	assign pop = wq_valid && wq_ready;
	assign wq_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + ($clog2(QDEPTH)+1)'(push) - ($clog2(QDEPTH)+1)'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= ($clog2(QDEPTH)+1)'(QDEPTH)) else $error("queue overflow");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0) else $error("pop from empty queue");
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count slip");
`endif

endmodule

>>> sv/frt_back.sv
// ----------------------------------------------------------------------------
// Fragment reassembly tracker table engine
// Looks up the tensor entry, checks the fragment and updates the table.
// ----------------------------------------------------------------------------
module frt_back import frt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wq_valid,
	output logic        wq_ready,
	input  work_t       wq_data,
	input  logic [31:0] buf_limit,
	frt_out_if.source   out_ch
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t                   state_q;
	work_t                    item_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [63:0]              tid_q   [TABLE_ENTRIES];
	logic [31:0]              tb_q    [TABLE_ENTRIES];
	logic [15:0]              ft_q    [TABLE_ENTRIES];
	logic [6:0]               rc_q    [TABLE_ENTRIES];
	logic [MAX_FRAGMENTS-1:0] bm_q    [TABLE_ENTRIES];
	logic                     hit_q, free_q;
	logic [IDX_W-1:0]         slot_q;

	logic                     hit_c, free_c;
	logic [IDX_W-1:0]         hslot_c, fslot_c;
	logic                     obusy;
	frag_out_t                res;
	logic                     fresh, fail_max, do_upd, ok;
	logic [31:0]              e_tb;
	logic [15:0]              e_ft;
	logic [6:0]               e_rc, n_rc;
	logic [MAX_FRAGMENTS-1:0] e_bm, n_bm;
	logic                     seen;
	logic [32:0]              sum;
	logic                     n_valid;

	always_comb begin
		hit_c = 1'b0; free_c = 1'b0; hslot_c = '0; fslot_c = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (valid_q[i]) begin
				if (!hit_c && tid_q[i] == wq_data.tensor_tag) begin
					hit_c = 1'b1; hslot_c = IDX_W'(i);
				end
			end else if (!free_c) begin
				free_c = 1'b1; fslot_c = IDX_W'(i);
			end
		end
	end

	assign obusy = out_ch.valid && !out_ch.ready;
	assign wq_ready = (state_q == S_IDLE);

	always_comb begin
		fresh = !hit_q || (tb_q[slot_q] == '0);
		fail_max = fresh && (item_q.fragment_total > 16'(MAX_FRAGMENTS));
		e_tb = fresh ? item_q.total_bytes : tb_q[slot_q];
		e_ft = fresh ? item_q.fragment_total : ft_q[slot_q];
		e_rc = fresh ? '0 : rc_q[slot_q];
		e_bm = fresh ? '0 : bm_q[slot_q];
		seen = (item_q.fragment_number < 16'(MAX_FRAGMENTS)) &&
			e_bm[item_q.fragment_number[FNUM_W-1:0]];
		sum = {1'b0, item_q.byte_offset} + 33'(item_q.payload_bytes);
		res = '0;
		ok = 1'b0;
		do_upd = 1'b0;
		n_valid = 1'b1;
		n_bm = e_bm;
		n_rc = e_rc;
		if (item_q.drop) begin
			res.status = item_q.drop_status;
		end else if (!hit_q && !free_q) begin
			res.status = ST_FULL;
		end else if (fail_max) begin
			res.status = ST_FULL;
			do_upd = 1'b1;
			n_valid = 1'b0;
		end else begin
			do_upd = 1'b1;
			if (item_q.fragment_number >= e_ft || seen) begin
				res.status = ST_DUPLICATE;
			end else if (sum > {1'b0, e_tb}) begin
				res.status = ST_OVERRUN;
			end else begin
				ok = 1'b1;
				res.status = ST_OK;
				res.write_offset = item_q.byte_offset;
				res.write_length = item_q.payload_bytes;
				n_bm[item_q.fragment_number[FNUM_W-1:0]] = 1'b1;
				n_rc = e_rc + 7'd1;
			end
			if ({9'd0, n_rc} == e_ft) begin
				res.complete = 1'b1;
				res.done_tensor_tag = item_q.tensor_tag;
				res.copy_length = (e_tb < buf_limit) ? e_tb : buf_limit;
				n_valid = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wq_valid && wq_ready) begin
			item_q <= wq_data;
			hit_q <= hit_c;
			free_q <= free_c;
			slot_q <= hit_c ? hslot_c : fslot_c;
		end
		if (state_q == S_EXEC && !obusy) begin
			out_ch.data <= res;
			if (do_upd && !fail_max) begin
				tid_q[slot_q] <= item_q.tensor_tag;
				tb_q[slot_q] <= e_tb;
				ft_q[slot_q] <= e_ft;
				rc_q[slot_q] <= n_rc;
				bm_q[slot_q] <= n_bm;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			out_ch.valid <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
					if (wq_valid) state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (!obusy) begin
						out_ch.valid <= 1'b1;
						if (do_upd) valid_q[slot_q] <= n_valid;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("state corrupt");
	a_out_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_ch.valid) |-> $past(state_q) == S_EXEC) else $error("stray result");
	a_accept_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && !obusy && ok) |=> out_ch.data.write_length ==
		$past(item_q.payload_bytes)) else $error("length mismatch");
`endif

endmodule

>>> sv/fragment_reassembly_tracker_top.sv
// A header is written into the queue, taken by the table engine in its idle state, and its result
// is registered in the execute state; an output stall holds the execute state.
// The table engine takes no new header until the read-modify-write for the last one is done.
// A two-entry queue decouples header acceptance from table processing.
// Reset clears all entry valid bits and the queue at once; no clearing pass.
// ----------------------------------------------------------------------------
// Fragment reassembly tracker
// Tracks per-tensor fragment bitmaps and reports write windows and completion.
// ----------------------------------------------------------------------------
module fragment_reassembly_tracker_top import frt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	frt_in_if.sink      in_ch,
	frt_out_if.source   out_ch,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_wdata
);

	logic [15:0] ethertype_q;
	logic [31:0] buf_limit_q;
	logic        wq_valid, wq_ready;
	work_t       wq_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ethertype_q <= '0;
			buf_limit_q <= '1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ETHERTYPE: ethertype_q <= cfg_wdata[15:0];
				CFG_BUF_LIMIT: buf_limit_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	frt_front u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .ethertype(ethertype_q),
		.wq_valid(wq_valid), .wq_ready(wq_ready), .wq_data(wq_data)
	);

	frt_back u_back (
		.clk(clk), .arst_n(arst_n), .wq_valid(wq_valid), .wq_ready(wq_ready),
		.wq_data(wq_data), .buf_limit(buf_limit_q), .out_ch(out_ch)
	);

endmodule

>>> test/tb_fragment_reassembly_tracker_top.sv
// ----------------------------------------------------------------------------
// Fragment reassembly tracker testbench
// Drives fragment headers through the valid/ready channels, predicts each
// result from a private copy of the tensor table and checks every field.
// ----------------------------------------------------------------------------
module tb_fragment_reassembly_tracker_top;
	import frt_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [31:0] cfg_wdata;

	frt_in_if  in_ch ();
	frt_out_if out_ch ();

	fragment_reassembly_tracker_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	frag_in_t  pending_hdrs[$];
	frag_out_t expected_results[$];
	int        n_errors = 0;
	bit        quiet = 1'b0;
	int        hold_seq = 0;

	logic [15:0] ethertype_cfg;
	logic [31:0] limit_cfg;
	logic        tbl_valid[TABLE_ENTRIES];
	logic [63:0] tbl_id[TABLE_ENTRIES];
	logic [31:0] tbl_total[TABLE_ENTRIES];
	logic [15:0] tbl_ftotal[TABLE_ENTRIES];
	logic [6:0]  tbl_count[TABLE_ENTRIES];
	logic [63:0] tbl_seen[TABLE_ENTRIES];

	function automatic frag_in_t make_hdr(logic [15:0] flen, logic [15:0] et, logic [63:0] id,
			logic [31:0] total, logic [15:0] ftot, logic [15:0] fnum, logic [31:0] off,
			logic [15:0] plen);
		frag_in_t h;
		h.frame_length    = flen;
		h.frame_ethertype = et;
		h.tensor_tag      = id;
		h.total_bytes     = total;
		h.fragment_total  = ftot;
		h.fragment_number = fnum;
		h.byte_offset     = off;
		h.payload_bytes   = plen;
		return h;
	endfunction

	task automatic track_fragment(input frag_in_t h);
		frag_out_t r;
		int        slot;
		int        free_slot;
		bit        fresh;
		r = '0;
		slot = -1;
		free_slot = -1;
		if (h.frame_length < MIN_FRAME_BYTES) begin
			r.status = ST_RUNT;
		end else if (h.frame_ethertype != ethertype_cfg) begin
			r.status = ST_ETHERTYPE;
		end else begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (tbl_valid[i]) begin
					if (slot < 0 && tbl_id[i] == h.tensor_tag)
						slot = i;
				end else if (free_slot < 0) begin
					free_slot = i;
				end
			end
			if (slot < 0 && free_slot < 0) begin
				r.status = ST_FULL;
			end else begin
				fresh = (slot < 0) || (tbl_total[slot] == 0);
				if (slot < 0)
					slot = free_slot;
				if (fresh && h.fragment_total > MAX_FRAGMENTS) begin
					tbl_valid[slot] = 1'b0;
					r.status = ST_FULL;
				end else begin
					if (fresh) begin
						tbl_valid[slot]  = 1'b1;
						tbl_id[slot]     = h.tensor_tag;
						tbl_total[slot]  = h.total_bytes;
						tbl_ftotal[slot] = h.fragment_total;
						tbl_count[slot]  = '0;
						tbl_seen[slot]   = '0;
					end
					if (h.fragment_number >= tbl_ftotal[slot] ||
							tbl_seen[slot][h.fragment_number[5:0]]) begin
						r.status = ST_DUPLICATE;
					end else if ({1'b0, h.byte_offset} + {17'b0, h.payload_bytes} >
							{1'b0, tbl_total[slot]}) begin
						r.status = ST_OVERRUN;
					end else begin
						r.status = ST_OK;
						r.write_offset = h.byte_offset;
						r.write_length = h.payload_bytes;
						tbl_seen[slot][h.fragment_number[5:0]] = 1'b1;
						tbl_count[slot] = tbl_count[slot] + 7'd1;
					end
					if ({9'b0, tbl_count[slot]} == tbl_ftotal[slot]) begin
						r.complete = 1'b1;
						r.done_tensor_tag = tbl_id[slot];
						r.copy_length = (tbl_total[slot] < limit_cfg) ? tbl_total[slot]
							: limit_cfg;
						tbl_valid[slot] = 1'b0;
					end
				end
			end
		end
		expected_results.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		int gap;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data <= '0;
			gap = 0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (gap > 0) begin
				gap--;
				in_ch.valid <= 1'b0;
			end else if (pending_hdrs.size() > 0 && !quiet && $urandom_range(0, 7) == 0) begin
				gap = $urandom_range(0, 2);
				in_ch.valid <= 1'b0;
			end else if (pending_hdrs.size() > 0) begin
				in_ch.data <= pending_hdrs.pop_front();
				in_ch.valid <= 1'b1;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready)
			track_fragment(in_ch.data);
	end

	always @(posedge clk or negedge arst_n) begin
		int stall_left;
		int hold_seen;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			stall_left = 0;
			hold_seen = 0;
		end else if (hold_seen != hold_seq) begin
			hold_seen = hold_seq;
			stall_left = 80;
			out_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ch.ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 2);
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		frag_out_t want;
		frag_out_t got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = out_ch.data;
			if (expected_results.size() == 0) begin
				$error("unexpected result: status %0d", got.status);
				n_errors++;
			end else begin
				want = expected_results.pop_front();
				if (got.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, got.status);
					n_errors++;
				end
				if (got.write_offset !== want.write_offset) begin
					$error("write_offset: expected %0h, actual %0h", want.write_offset,
						got.write_offset);
					n_errors++;
				end
				if (got.write_length !== want.write_length) begin
					$error("write_length: expected %0h, actual %0h", want.write_length,
						got.write_length);
					n_errors++;
				end
				if (got.complete !== want.complete) begin
					$error("complete: expected %0d, actual %0d", want.complete, got.complete);
					n_errors++;
				end
				if (got.done_tensor_tag !== want.done_tensor_tag) begin
					$error("done_tensor_tag: expected %0h, actual %0h", want.done_tensor_tag,
						got.done_tensor_tag);
					n_errors++;
				end
				if (got.copy_length !== want.copy_length) begin
					$error("copy_length: expected %0h, actual %0h", want.copy_length,
						got.copy_length);
					n_errors++;
				end
			end
		end
	end

	task automatic write_reg(input logic idx, input logic [31:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		if (idx == CFG_ETHERTYPE)
			ethertype_cfg = value[15:0];
		else
			limit_cfg = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (pending_hdrs.size() != 0 || in_ch.valid || expected_results.size() != 0);
		repeat (6) @(posedge clk);
	endtask

	// Completes or releases every open entry so the next phase starts with a free table.
	task automatic flush_table();
		wait_drained();
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (!tbl_valid[i])
				continue;
			if (tbl_total[i] == 0) begin
				pending_hdrs.push_back(make_hdr(16'd64, ethertype_cfg, tbl_id[i], 32'd0,
					16'd0, 16'd0, 32'd0, 16'd0));
			end else begin
				for (int b = 0; b < tbl_ftotal[i]; b++)
					if (!tbl_seen[i][b])
						pending_hdrs.push_back(make_hdr(16'd64, ethertype_cfg, tbl_id[i],
							tbl_total[i], tbl_ftotal[i], 16'(b), 32'd0, 16'd0));
			end
		end
		wait_drained();
	endtask

	function automatic frag_in_t noise_hdr();
		frag_in_t h;
		h = make_hdr(16'($urandom), 16'($urandom), {$urandom, $urandom}, $urandom,
			16'($urandom), 16'($urandom), $urandom, 16'($urandom));
		case ($urandom_range(0, 2))
			0: h.frame_length = 16'($urandom_range(0, MIN_FRAME_BYTES - 1));
			1: h.frame_ethertype = ethertype_cfg ^ 16'($urandom_range(1, 65535));
			default: ;
		endcase
		return h;
	endfunction

	// Interleaved fragment sequences of a few tensors, with duplicates, losses,
	// overruns and stray headers mixed in.
	task automatic add_random_headers(input int n_items);
		frag_in_t batch[$];
		frag_in_t tmp;
		int       added;
		int       n_tensors;
		int       nfrag;
		int       chunk;
		int       j;
		logic [63:0] id;
		logic [31:0] total;
		added = 0;
		while (added < n_items) begin
			batch.delete();
			n_tensors = $urandom_range(1, 6);
			for (int t = 0; t < n_tensors; t++) begin
				case ($urandom_range(0, 19))
					0: nfrag = 0;
					1: nfrag = $urandom_range(MAX_FRAGMENTS + 1, 65535);
					2: nfrag = $urandom_range(9, MAX_FRAGMENTS);
					default: nfrag = $urandom_range(1, 8);
				endcase
				chunk = $urandom_range(1, 1500);
				id = ($urandom_range(0, 9) < 3) ? 64'($urandom_range(1, 20))
					: {$urandom, $urandom};
				total = (nfrag <= MAX_FRAGMENTS) ? 32'(nfrag * chunk) : $urandom;
				if ($urandom_range(0, 9) == 0)
					total = total + 32'($urandom_range(1, 100));
				if ($urandom_range(0, 29) == 0)
					total = '0;
				for (int f = 0; f < ((nfrag > 8 && nfrag > MAX_FRAGMENTS) ? 1
						: (nfrag == 0 ? 1 : nfrag)); f++) begin
					if ($urandom_range(0, 19) == 0)
						continue;
					tmp = make_hdr(16'($urandom_range(MIN_FRAME_BYTES, 65535)), ethertype_cfg,
						id, total, 16'(nfrag), 16'(f), 32'(f * chunk), 16'(chunk));
					if ($urandom_range(0, 19) == 0)
						tmp.payload_bytes = 16'($urandom_range(chunk + 1, 65535));
					batch.push_back(tmp);
					if ($urandom_range(0, 9) == 0)
						batch.push_back(tmp);
					if ($urandom_range(0, 29) == 0) begin
						tmp.fragment_number = 16'($urandom_range(nfrag, 65535));
						batch.push_back(tmp);
					end
				end
			end
			for (int k = batch.size() - 1; k > 0; k--) begin
				j = $urandom_range(0, k);
				tmp = batch[k];
				batch[k] = batch[j];
				batch[j] = tmp;
			end
			foreach (batch[k]) begin
				if ($urandom_range(0, 9) == 0) begin
					pending_hdrs.push_back(noise_hdr());
					added++;
				end
				pending_hdrs.push_back(batch[k]);
				added++;
			end
		end
	endtask

	initial begin
		logic [15:0] et_choice[6];
		logic [31:0] limit_choice[6];
		logic [15:0] et;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		ethertype_cfg = '0;
		limit_cfg = '1;
		for (int i = 0; i < TABLE_ENTRIES; i++)
			tbl_valid[i] = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(CFG_ETHERTYPE, 32'h88B5);
		write_reg(CFG_BUF_LIMIT, 32'hFFFF_FFFF);
		et = 16'h88B5;
		pending_hdrs.push_back(make_hdr(16'd37, et, 64'd1, 32'd10, 16'd1, 16'd0, 32'd0, 16'd1));
		pending_hdrs.push_back(make_hdr(16'd0, et, 64'd1, 32'd10, 16'd1, 16'd0, 32'd0, 16'd1));
		pending_hdrs.push_back(make_hdr(16'd38, et ^ 16'd1, 64'd1, 32'd10, 16'd1, 16'd0,
			32'd0, 16'd1));
		pending_hdrs.push_back(make_hdr(16'hFFFF, 16'hFFFF, 64'd1, 32'd10, 16'd1, 16'd0,
			32'd0, 16'd1));
		pending_hdrs.push_back(make_hdr(16'd38, et, '1, '1, 16'd1, 16'd0, 32'hFFFF_0000,
			16'hFFFF));
		pending_hdrs.push_back(make_hdr(16'd100, et, 64'd7, 32'd50, 16'd0, 16'd0, 32'd0,
			16'd5));
		pending_hdrs.push_back(make_hdr(16'd100, et, 64'd8, 32'd50, 16'd65, 16'd0, 32'd0,
			16'd5));
		pending_hdrs.push_back(make_hdr(16'd100, et, 64'd9, 32'd1000, 16'd64, 16'd63, 32'd0,
			16'd10));
		pending_hdrs.push_back(make_hdr(16'd100, et, 64'd9, 32'd1000, 16'd64, 16'd63, 32'd0,
			16'd10));
		pending_hdrs.push_back(make_hdr(16'd100, et, 64'd9, 32'd1000, 16'd64, 16'd64, 32'd0,
			16'd10));
		pending_hdrs.push_back(make_hdr(16'd100, et, 64'd9, 32'd1000, 16'd64, 16'd0,
			32'hFFFF_FFFF, 16'hFFFF));
		pending_hdrs.push_back(make_hdr(16'd100, et, 64'd10, 32'd0, 16'd2, 16'd0, 32'd0,
			16'd0));
		pending_hdrs.push_back(make_hdr(16'd100, et, 64'd10, 32'd0, 16'd1, 16'd0, 32'd0,
			16'd0));
		pending_hdrs.push_back(make_hdr(16'd100, et, 64'd11, 32'd20, 16'd2, 16'd0, 32'd0,
			16'd10));
		pending_hdrs.push_back(make_hdr(16'd100, et, 64'd11, 32'd20, 16'd2, 16'd1, 32'd10,
			16'd10));
		for (int i = 0; i < TABLE_ENTRIES; i++)
			pending_hdrs.push_back(make_hdr(16'd100, et, 64'(100 + i), 32'd20, 16'd2, 16'd0,
				32'd0, 16'd10));
		flush_table();

		et_choice = '{16'h0000, 16'hFFFF, 16'($urandom), 16'h88B5, 16'($urandom), 16'h0800};
		limit_choice = '{32'd0, 32'd1, 32'd100000, 32'hFFFF_FFFF, $urandom, 32'd4000};
		for (int r = 0; r < 6; r++) begin
			write_reg(CFG_ETHERTYPE, {16'b0, et_choice[r]});
			write_reg(CFG_BUF_LIMIT, limit_choice[r]);
			if (r == 5)
				quiet = 1'b1;
			add_random_headers(320);
			if (r == 1)
				hold_seq++;
			flush_table();
		end

		repeat (10) @(posedge clk);
		if (n_errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("Regression FAIL");
		$finish;
	end

endmodule
